// ----- rtl/spg_pkg.sv -----
// Shared types and constants for the stepper pulse generator.
`timescale 1ns / 1ps

package spg_pkg;

  localparam int TICK_W     = 20;
  localparam int POS_W      = 32;
  localparam int HIGH_W     = 10;
  localparam int RATE_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [TICK_W-1:0] TICK_MAX       = '1;
  localparam logic [TICK_W-1:0] LOW_SHORT      = TICK_W'(2);
  localparam logic [HIGH_W-1:0] HIGH_RESET_VAL = HIGH_W'(5);

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_MOVE_REL = 2'd1,
    CMD_MOVE_ABS = 2'd2,
    CMD_SET_HOME = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_TIME = 2'd0,
    CFG_MODE_ZERO = 2'd1,
    CFG_MODE_TWO  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_HI  = 3'd1,
    PH_RST_LO  = 3'd2,
    PH_DIR     = 3'd3,
    PH_STEP_HI = 3'd4,
    PH_STEP_LO = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_HOME,
    S_CHECK,
    S_DIV,
    S_SETUP,
    S_WB
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [POS_W-1:0] distance;
    logic [RATE_W-1:0]       rate_hz;
  } in_item_t;

  typedef struct packed {
    logic                    step_clock;
    logic                    dir_level;
    logic                    driver_reset;
    logic                    busy_res;
    logic                    move_done;
    logic signed [POS_W-1:0] position;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic calc_delta;
    logic start_move;
    logic jump;
    logic div_step;
    logic setup;
    logic tick;
    logic home;
    logic load_out;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic busy;
    logic delta_zero;
    logic rate_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ----- rtl/spg_ctrl.sv -----
// Controller state machine: item handshake and sequencing of datapath operations.
`timescale 1ns / 1ps

module spg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  spg_pkg::dp_status_t status,
  output spg_pkg::dp_ctl_t    ctl
);
  import spg_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (status.cmd == CMD_TICK)          state_nxt = S_TICK;
        else if (status.busy)                state_nxt = S_WB;
        else if (status.cmd == CMD_SET_HOME) state_nxt = S_HOME;
        else                                 state_nxt = S_CHECK;
      end
      S_TICK:  state_nxt = S_WB;
      S_HOME:  state_nxt = S_WB;
      S_CHECK: begin
        if (status.delta_zero || status.rate_zero) state_nxt = S_WB;
        else                                       state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_SETUP;
      end
      S_SETUP: state_nxt = S_WB;
      S_WB: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE:   ctl.latch      = in_valid;
      S_DECODE: ctl.calc_delta = 1'b1;
      S_TICK:   ctl.tick       = 1'b1;
      S_HOME:   ctl.home       = 1'b1;
      S_CHECK: begin
        ctl.jump       = !status.delta_zero && status.rate_zero;
        ctl.start_move = !status.delta_zero && !status.rate_zero;
      end
      S_DIV:    ctl.div_step   = !status.div_done;
      S_SETUP:  ctl.setup      = 1'b1;
      S_WB:     ctl.load_out   = out_free;
      default:  ctl = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ctl.load_out)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/spg_datapath.sv -----
// Datapath: move sequencer state, position, period divider and result register.
`timescale 1ns / 1ps

module spg_datapath #(
  parameter int TICKS_PER_SECOND  = 1000000,
  parameter int RESET_PHASE_TICKS = 5,
  parameter int DIR_SETUP_TICKS   = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spg_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [spg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  spg_pkg::dp_ctl_t                    ctl,
  output spg_pkg::dp_status_t                 status,
  output spg_pkg::out_item_t                  out_data
);
  import spg_pkg::*;

  localparam int QW = $clog2(TICKS_PER_SECOND + 1);
  localparam int CW = $clog2(QW + 1);
  localparam int LW = (QW > TICK_W) ? QW : TICK_W;

  localparam logic [QW-1:0]     DIVIDEND  = QW'(TICKS_PER_SECOND);
  localparam logic [TICK_W-1:0] RST_TICKS = TICK_W'(RESET_PHASE_TICKS);
  localparam logic [TICK_W-1:0] DIR_TICKS = TICK_W'(DIR_SETUP_TICKS);

  in_item_t           item_r;
  logic [POS_W-1:0]   delta_r, delta_nxt;
  logic               done_r, done_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [POS_W-1:0]   steps_r, steps_nxt;
  logic [TICK_W-1:0]  low_r, low_nxt;
  logic [POS_W-1:0]   amount_r, amount_nxt;
  logic               neg_r, neg_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               dir_r, dir_nxt;
  logic [HIGH_W-1:0]  hi_r, hi_nxt;
  out_item_t          out_r;

  // Restoring divider for the step period.
  logic [QW-1:0]      dvd_r;
  logic [RATE_W:0]    rem_r;
  logic [QW-1:0]      quo_r;
  logic [RATE_W-1:0]  divisor_r;
  logic [CW-1:0]      cnt_r;
  logic [RATE_W:0]    rem_sh;
  logic               rem_ge;

  logic [TICK_W-1:0]  hi_now;
  logic [QW-1:0]      hi_ext;
  logic [LW-1:0]      diff_ext;

  assign hi_now   = (hi_r == '0) ? TICK_W'(1) : TICK_W'(hi_r);
  assign hi_ext   = QW'(hi_r == '0 ? HIGH_W'(1) : hi_r);
  assign diff_ext = LW'(quo_r - hi_ext);

  assign rem_sh = {rem_r[RATE_W-1:0], dvd_r[QW-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor_r});

  assign status.cmd        = cmd_t'(item_r.command);
  assign status.busy       = (phase_r != PH_IDLE);
  assign status.delta_zero = (delta_r == '0);
  assign status.rate_zero  = (item_r.rate_hz == '0);
  assign status.div_done   = (cnt_r == '0);

  assign out_data = out_r;

  always_comb begin
    delta_nxt  = delta_r;
    done_nxt   = done_r;
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    steps_nxt  = steps_r;
    low_nxt    = low_r;
    amount_nxt = amount_r;
    neg_nxt    = neg_r;
    pos_nxt    = pos_r;
    dir_nxt    = dir_r;
    hi_nxt     = hi_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_TIME: hi_nxt = cfg_wdata[HIGH_W-1:0];
        // The mode select lines do not influence any result of this block.
        CFG_MODE_ZERO, CFG_MODE_TWO: ;
        default: ;
      endcase
    end

    if (ctl.latch) done_nxt = 1'b0;

    if (ctl.calc_delta) begin
      if (item_r.command == CMD_MOVE_ABS) delta_nxt = item_r.distance - pos_r;
      else                                delta_nxt = item_r.distance;
    end

    if (ctl.jump) begin
      pos_nxt  = pos_r + delta_r;
      done_nxt = 1'b1;
    end

    if (ctl.start_move) begin
      neg_nxt    = delta_r[POS_W-1];
      amount_nxt = delta_r[POS_W-1] ? (POS_W'(0) - delta_r) : delta_r;
      steps_nxt  = amount_nxt;
    end

    if (ctl.setup) begin
      if (quo_r > hi_ext) begin
        if (diff_ext > LW'(TICK_MAX)) low_nxt = TICK_MAX;
        else                          low_nxt = diff_ext[TICK_W-1:0];
      end else begin
        low_nxt = LOW_SHORT;
      end
      phase_nxt = PH_RST_HI;
      ticks_nxt = RST_TICKS;
    end

    if (ctl.home) pos_nxt = '0;

    if (ctl.tick && phase_r != PH_IDLE) begin
      if (ticks_r > TICK_W'(1)) begin
        ticks_nxt = ticks_r - TICK_W'(1);
      end else begin
        case (phase_r)
          PH_RST_HI: begin
            phase_nxt = PH_RST_LO;
            ticks_nxt = RST_TICKS;
          end
          PH_RST_LO: begin
            phase_nxt = PH_DIR;
            dir_nxt   = neg_r;
            ticks_nxt = DIR_TICKS;
          end
          PH_DIR: begin
            phase_nxt = PH_STEP_HI;
            ticks_nxt = hi_now;
          end
          PH_STEP_HI: begin
            phase_nxt = PH_STEP_LO;
            ticks_nxt = low_r;
          end
          default: begin
            steps_nxt = steps_r - POS_W'(1);
            if (steps_r != POS_W'(1)) begin
              phase_nxt = PH_STEP_HI;
              ticks_nxt = hi_now;
            end else begin
              phase_nxt = PH_IDLE;
              ticks_nxt = '0;
              pos_nxt   = neg_r ? (pos_r - amount_r) : (pos_r + amount_r);
              done_nxt  = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= 1'b0;
      phase_r  <= PH_IDLE;
      ticks_r  <= '0;
      steps_r  <= '0;
      low_r    <= '0;
      amount_r <= '0;
      neg_r    <= 1'b0;
      pos_r    <= '0;
      dir_r    <= 1'b0;
      hi_r     <= HIGH_RESET_VAL;
      cnt_r    <= '0;
    end else begin
      done_r   <= done_nxt;
      phase_r  <= phase_nxt;
      ticks_r  <= ticks_nxt;
      steps_r  <= steps_nxt;
      low_r    <= low_nxt;
      amount_r <= amount_nxt;
      neg_r    <= neg_nxt;
      pos_r    <= pos_nxt;
      dir_r    <= dir_nxt;
      hi_r     <= hi_nxt;
      if (ctl.start_move)    cnt_r <= CW'(QW);
      else if (ctl.div_step) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) item_r <= in_data;
    delta_r <= delta_nxt;
    if (ctl.start_move) begin
      dvd_r     <= DIVIDEND;
      rem_r     <= '0;
      quo_r     <= '0;
      divisor_r <= item_r.rate_hz;
    end else if (ctl.div_step) begin
      dvd_r <= {dvd_r[QW-2:0], 1'b0};
      rem_r <= rem_ge ? (rem_sh - {1'b0, divisor_r}) : rem_sh;
      quo_r <= {quo_r[QW-2:0], rem_ge};
    end
    if (ctl.load_out) begin
      out_r.step_clock   <= (phase_r == PH_STEP_HI);
      out_r.dir_level    <= dir_r;
      out_r.driver_reset <= (phase_r == PH_RST_HI);
      out_r.busy_res     <= (phase_r != PH_IDLE);
      out_r.move_done    <= done_r;
      out_r.position     <= pos_r;
    end
  end

endmodule

// ----- rtl/stepper_pulse_generator_with_position.sv -----
// Top level of the stepper step/direction pulse generator with position tracking.
// Items are accepted one at a time; move and set-home commands that arrive while a move runs
// are ignored. A move start also runs the period divider, one quotient bit per cycle, with QW
// the bit width of TICKS_PER_SECOND. A stalled result holds the next item off.
// Synchronous active-low reset idles the sequencer, clears the position, sets high time to 5.
`timescale 1ns / 1ps

module stepper_pulse_generator_with_position #(
  parameter int TICKS_PER_SECOND  = 1000000,
  parameter int RESET_PHASE_TICKS = 5,
  parameter int DIR_SETUP_TICKS   = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spg_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spg_pkg::*;

  dp_ctl_t    ctl;
  dp_status_t status;

  spg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctl       (ctl)
  );

  spg_datapath #(
    .TICKS_PER_SECOND  (TICKS_PER_SECOND),
    .RESET_PHASE_TICKS (RESET_PHASE_TICKS),
    .DIR_SETUP_TICKS   (DIR_SETUP_TICKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
